// ----- rtl/bsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg: shared types for the bouncing sprite motion block
// Request payloads, configuration register set and register indexes.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int CfgAddrWidth = 5;

  typedef enum logic [2:0] {
    REG_LIMIT_X      = 3'd0,
    REG_LIMIT_Y      = 3'd1,
    REG_START_X      = 3'd2,
    REG_START_Y      = 3'd3,
    REG_START_VEL_X  = 3'd4,
    REG_START_VEL_Y  = 3'd5,
    REG_START_COLOR  = 3'd6,
    REG_FLASH_FRAMES = 3'd7
  } reg_idx_t;

  localparam logic [11:0] RstLimitX      = 12'd1600;
  localparam logic [11:0] RstLimitY      = 12'd810;
  localparam logic [11:0] RstStartX      = 12'd0;
  localparam logic [11:0] RstStartY      = 12'd0;
  localparam logic [11:0] RstStartVelX   = 12'd34;
  localparam logic [11:0] RstStartVelY   = 12'd34;
  localparam logic [2:0]  RstStartColor  = 3'd0;
  localparam logic [7:0]  RstFlashFrames = 8'd30;

  typedef struct packed {
    logic [11:0] limit_x;
    logic [11:0] limit_y;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [11:0] start_vel_x;
    logic [11:0] start_vel_y;
    logic [2:0]  start_color;
    logic [7:0]  flash_frames;
  } cfg_t;

  typedef struct packed {
    logic       restart;
    logic [2:0] random_pick;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [3:0]  image_slot;
    logic        bounced_x;
    logic        bounced_y;
    logic        corner_hit;
  } out_item_t;

endpackage

// ----- rtl/bsm_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_cfg: configuration register file
// APB-style write/read access to the eight motion registers.
// ----------------------------------------------------------------------------
module bsm_cfg
  import bsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CfgAddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_x      <= RstLimitX;
      cfg_r.limit_y      <= RstLimitY;
      cfg_r.start_x      <= RstStartX;
      cfg_r.start_y      <= RstStartY;
      cfg_r.start_vel_x  <= RstStartVelX;
      cfg_r.start_vel_y  <= RstStartVelY;
      cfg_r.start_color  <= RstStartColor;
      cfg_r.flash_frames <= RstFlashFrames;
    end else if (wr_en) begin
      case (idx)
        REG_LIMIT_X:      cfg_r.limit_x      <= pwdata[11:0];
        REG_LIMIT_Y:      cfg_r.limit_y      <= pwdata[11:0];
        REG_START_X:      cfg_r.start_x      <= pwdata[11:0];
        REG_START_Y:      cfg_r.start_y      <= pwdata[11:0];
        REG_START_VEL_X:  cfg_r.start_vel_x  <= pwdata[11:0];
        REG_START_VEL_Y:  cfg_r.start_vel_y  <= pwdata[11:0];
        REG_START_COLOR:  cfg_r.start_color  <= pwdata[2:0];
        REG_FLASH_FRAMES: cfg_r.flash_frames <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LIMIT_X:      prdata = {20'd0, cfg_r.limit_x};
      REG_LIMIT_Y:      prdata = {20'd0, cfg_r.limit_y};
      REG_START_X:      prdata = {20'd0, cfg_r.start_x};
      REG_START_Y:      prdata = {20'd0, cfg_r.start_y};
      REG_START_VEL_X:  prdata = {20'd0, cfg_r.start_vel_x};
      REG_START_VEL_Y:  prdata = {20'd0, cfg_r.start_vel_y};
      REG_START_COLOR:  prdata = {29'd0, cfg_r.start_color};
      REG_FLASH_FRAMES: prdata = {24'd0, cfg_r.flash_frames};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/bsm_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_axis: one axis of sprite motion
// Adds velocity to position, clamps at 0 or the limit and reflects velocity.
// ----------------------------------------------------------------------------
module bsm_axis #(
  parameter int FRACTION_BITS = 4
) (
  input  logic [12+FRACTION_BITS-1:0] pos_i,
  input  logic signed [10:0]          vel_i,
  input  logic [11:0]                 limit,
  output logic [12+FRACTION_BITS-1:0] pos_o,
  output logic signed [10:0]          vel_o,
  output logic                        hit
);

  localparam int PW = 12 + FRACTION_BITS;

  logic [PW-1:0]          lim;
  logic signed [PW+1:0]   sum;
  logic signed [10:0]     vel_abs;
  logic                   hit_lo;
  logic                   hit_hi;

  assign lim     = PW'(limit) << FRACTION_BITS;
  assign sum     = $signed({2'b00, pos_i}) + (PW+2)'(vel_i);
  assign vel_abs = vel_i[10] ? -vel_i : vel_i;
  assign hit_lo  = (sum <= 0);
  assign hit_hi  = !hit_lo && (sum >= $signed({2'b00, lim}));
  assign hit     = hit_lo || hit_hi;

  always_comb begin
    if (hit_lo) begin
      pos_o = '0;
      vel_o = vel_abs;
    end else if (hit_hi) begin
      pos_o = lim;
      vel_o = -vel_abs;
    end else begin
      pos_o = sum[PW-1:0];
      vel_o = vel_i;
    end
  end

endmodule

// ----- rtl/bsm_color.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_color: palette index selection
// New color on a bounce skipping the current one; start color reduction.
// ----------------------------------------------------------------------------
module bsm_color #(
  parameter int PALETTE_COUNT = 8
) (
  input  logic [$clog2(PALETTE_COUNT)-1:0] cur,
  input  logic [2:0]                       random_pick,
  input  logic [2:0]                       start_color,
  output logic [$clog2(PALETTE_COUNT)-1:0] picked,
  output logic [$clog2(PALETTE_COUNT)-1:0] start_idx
);

  localparam int CW = $clog2(PALETTE_COUNT);
  localparam logic [4:0] PalCnt  = 5'(PALETTE_COUNT);
  localparam logic [4:0] PickCnt = 5'(PALETTE_COUNT - 1);

  logic [2:0]    rmod;
  logic [2:0]    smod;
  logic [CW-1:0] c;

  // operands are 3 bits, so at most seven subtract steps
  always_comb begin
    rmod = random_pick;
    smod = start_color;
    for (int i = 0; i < 7; i++) begin
      if (5'(rmod) >= PickCnt) rmod = rmod - PickCnt[2:0];
      if (5'(smod) >= PalCnt)  smod = smod - PalCnt[2:0];
    end
    c = CW'(rmod);
    if (c >= cur) c = c + 1'b1;
    picked    = c;
    start_idx = CW'(smod);
  end

endmodule

// ----- rtl/bouncing_sprite_motion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bouncing_sprite_motion: frame-tick sprite motion with edge bounce
// Fixed-point position update, bounce color change and corner flash.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------
//   in      | input     | in_valid / in_ready  | in_data  (restart, random_pick)
//   out     | output    | out_valid / out_ready| out_data (position, slot, flags)
//   cfg     | input     | psel/penable/pready  | paddr, pwdata, prdata
//
// One request per clock sustained while out_ready is high; an accepted
// request passes the input register, then the result register. The motion
// state loop (add, clamp, color pick, flash count) closes between the two.
// Synchronous reset clears state to zero and loads register defaults.
// A stalled result holds in the output register while one more request
// waits in the input register.
// ----------------------------------------------------------------------------
module bouncing_sprite_motion
  import bsm_pkg::*;
#(
  parameter int PALETTE_COUNT = 8,
  parameter int FRACTION_BITS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int PW = 12 + FRACTION_BITS;
  localparam int CW = $clog2(PALETTE_COUNT);
  localparam logic [4:0] FlashSlot = 5'(PALETTE_COUNT);

  cfg_t cfg;

  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  logic      out_vld_r;

  logic [PW-1:0]      pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [10:0] vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic [CW-1:0]      color_r, color_nxt;
  logic [7:0]         flash_r, flash_nxt;

  logic [PW-1:0]      mv_pos_x, mv_pos_y;
  logic signed [10:0] mv_vel_x, mv_vel_y;
  logic               hit_x, hit_y;
  logic [CW-1:0]      picked, start_idx;
  logic [7:0]         flash_mid;
  logic [3:0]         slot;
  logic               adv;

  function automatic logic signed [10:0] sat_vel(input logic [11:0] v);
    logic signed [11:0] s;
    s = $signed(v);
    if (s > 12'sd1023) return 11'sd1023;
    else if (s < -12'sd1023) return -11'sd1023;
    else return s[10:0];
  endfunction

  bsm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsm_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_x (
    .pos_i (pos_x_r),
    .vel_i (vel_x_r),
    .limit (cfg.limit_x),
    .pos_o (mv_pos_x),
    .vel_o (mv_vel_x),
    .hit   (hit_x)
  );

  bsm_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_y (
    .pos_i (pos_y_r),
    .vel_i (vel_y_r),
    .limit (cfg.limit_y),
    .pos_o (mv_pos_y),
    .vel_o (mv_vel_y),
    .hit   (hit_y)
  );

  bsm_color #(.PALETTE_COUNT(PALETTE_COUNT)) u_color (
    .cur         (color_r),
    .random_pick (in_r.random_pick),
    .start_color (cfg.start_color),
    .picked      (picked),
    .start_idx   (start_idx)
  );

  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    flash_mid = (hit_x && hit_y) ? cfg.flash_frames : flash_r;
    if (in_r.restart) begin
      pos_x_nxt = PW'(cfg.start_x) << FRACTION_BITS;
      pos_y_nxt = PW'(cfg.start_y) << FRACTION_BITS;
      vel_x_nxt = sat_vel(cfg.start_vel_x);
      vel_y_nxt = sat_vel(cfg.start_vel_y);
      color_nxt = start_idx;
      flash_nxt = '0;
      slot      = 4'(start_idx);
    end else begin
      pos_x_nxt = mv_pos_x;
      pos_y_nxt = mv_pos_y;
      vel_x_nxt = mv_vel_x;
      vel_y_nxt = mv_vel_y;
      color_nxt = (hit_x || hit_y) ? picked : color_r;
      if (flash_mid != 8'd0) begin
        flash_nxt = flash_mid - 8'd1;
        slot      = FlashSlot[3:0];
      end else begin
        flash_nxt = flash_mid;
        slot      = 4'(color_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      vel_x_r   <= '0;
      vel_y_r   <= '0;
      color_r   <= '0;
      flash_r   <= '0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (adv) begin
        out_vld_r <= 1'b1;
        pos_x_r   <= pos_x_nxt;
        pos_y_r   <= pos_y_nxt;
        vel_x_r   <= vel_x_nxt;
        vel_y_r   <= vel_y_nxt;
        color_r   <= color_nxt;
        flash_r   <= flash_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_r <= in_data;
    if (adv) begin
      out_r.pos_x      <= 12'(pos_x_nxt >> FRACTION_BITS);
      out_r.pos_y      <= 12'(pos_y_nxt >> FRACTION_BITS);
      out_r.image_slot <= slot;
      out_r.bounced_x  <= !in_r.restart && hit_x;
      out_r.bounced_y  <= !in_r.restart && hit_y;
      out_r.corner_hit <= !in_r.restart && hit_x && hit_y;
    end
  end

endmodule

// ----- rtl/bsm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_checker: port-level checks for bouncing_sprite_motion
// Result flag consistency, slot range, reset, output hold and no result without request.
// ----------------------------------------------------------------------------
module bsm_checker
  import bsm_pkg::*;
#(
  parameter int PALETTE_COUNT = 8
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  localparam logic [4:0] MaxSlot = 5'(PALETTE_COUNT);

  a_corner_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.corner_hit == (out_data.bounced_x && out_data.bounced_y)))
    else $error("corner_hit disagrees with bounce flags");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.image_slot} <= MaxSlot))
    else $error("image_slot out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // nothing taken now or in the previous cycle, so the input register is empty
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result without request");

endmodule

bind bouncing_sprite_motion bsm_checker #(.PALETTE_COUNT(PALETTE_COUNT)) u_bsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
